// ----- src/b2da_pkg.sv -----
// Shared constants and controller/datapath interface types for the binary to decimal converter.
package b2da_pkg;

	localparam int VALUE_BITS  = 31;
	localparam int MAX_DIGITS  = 10;
	localparam int CNT_W       = $clog2(MAX_DIGITS);
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 6;
	localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;

	// Divide by ten as a multiply by ceil(2^35 / 10) and a right shift by 35.
	// This is exact for every operand below 2^32.
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 35;
	localparam logic [RECIP_W-1:0] RECIP = 32'hCCCC_CCCD;
	localparam int PROD_W      = VALUE_BITS + RECIP_W;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef struct packed {
		logic load;   // capture a new value and clear the digit counter
		logic div;    // one divide-by-ten step, store the remainder
		logic emit;   // move the digit at the counter into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic quot_zero; // the current quotient is zero, so this is the top digit
		logic cnt_zero;  // the counter points at the least significant digit
		logic out_free;  // the output register can take a digit this cycle
	} dp_sts_t;

endpackage

// ----- src/b2da_ctrl.sv -----
// Controller state machine sequencing the divide and emit phases.
module b2da_ctrl import b2da_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (sts.quot_zero) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
				if (sts.out_free && sts.cnt_zero) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/b2da_datapath.sv -----
// Datapath: divide-by-ten unit, digit buffer, digit counter and output register.
module b2da_datapath import b2da_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [CHAR_W-1:0]     out_char,
	output logic                  out_last
);

	logic [VALUE_BITS-1:0] val_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIGIT_W-1:0]    digits_q [MAX_DIGITS];
	logic                  valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	logic [PROD_W-1:0]     prod;
	logic [VALUE_BITS-1:0] quot;
	logic [VALUE_BITS-1:0] rem_full;
	logic [DIGIT_W-1:0]    rem;

	// The remainder is v - 10*q, formed with two shifts and adds.
	always_comb begin
		prod     = PROD_W'(val_q) * PROD_W'(RECIP);
		quot     = VALUE_BITS'(prod >> RECIP_SHIFT);
		rem_full = val_q - ((quot << 3) + (quot << 1));
		rem      = rem_full[DIGIT_W-1:0];
	end

	assign sts.quot_zero = (quot == '0);
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.out_free  = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div && !sts.quot_zero) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.emit && !sts.cnt_zero) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
		end else if (cmd.div) begin
			val_q <= quot;
		end
		if (cmd.div) begin
			digits_q[cnt_q] <= rem;
		end
		if (cmd.emit) begin
			char_q <= ASCII_ZERO + CHAR_W'(digits_q[cnt_q]);
			last_q <= sts.cnt_zero;
		end
	end

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule

// ----- src/binary_to_decimal_ascii.sv -----
// Top level of the binary to decimal ASCII converter.
// A value of up to 31 bits arrives in one transfer on the slave stream and leaves as its
// decimal text, one ASCII digit per master transfer, most significant digit first, with
// tlast on the least significant digit; zero gives the single digit '0'. One item is worked
// on at a time. After the input transfer the datapath makes one digit per cycle by dividing
// the held value by ten (a multiply by a fixed reciprocal and a shift), storing the remainders
// in a ten-entry digit buffer, until the quotient reaches zero; it then reads the buffer back
// from the top digit into the output register, one digit per cycle while the sink keeps up.
// The next input transfer is taken as soon as the last digit has entered the output register,
// even while that digit still waits to be taken.
module binary_to_decimal_ascii import b2da_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [30:0] value, [31] zero fill
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero fill
	output logic                   m_tlast    // last_digit
);

	dp_cmd_t           cmd;
	dp_sts_t           sts;
	logic [CHAR_W-1:0] digit_char;

	// The controller decides when to load, divide and emit; the datapath does the arithmetic
	// and holds the digits and the output register.
	b2da_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	b2da_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (s_tdata[VALUE_BITS-1:0]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_char  (digit_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(OUT_TDATA_W - CHAR_W){1'b0}}, digit_char};

	// Every digit shown on the master side is an ASCII decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[CHAR_W-1:0] >= ASCII_ZERO) &&
		(m_tdata[CHAR_W-1:0] <= ASCII_ZERO + CHAR_W'(9)))
		else $error("digit outside the ASCII decimal range");

	// An accepted input makes the converter busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while the previous value was still loading");

	// Once the final digit reaches the output register the converter is free again.
	a_free_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid && m_tlast) |-> s_tready)
		else $error("converter still busy after the last digit was produced");

	// While a digit run is in progress no new input is taken.
	a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of a digit run");

endmodule

// ----- sim/b2da_checker.sv -----
// Watches both streams of the decimal converter, predicts its digit text and compares.
module b2da_checker import b2da_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tlast,
	input  logic                   drained_check,
	output int                     errors,
	output int                     pending,
	output int                     values_seen,
	output int                     digits_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} digit_t;

	digit_t expected_digits[$];

	initial begin
		errors      = 0;
		pending     = 0;
		values_seen = 0;
		digits_seen = 0;
	end

	task automatic report(input string what);
		$display("%0t ns: error: %s", $realtime, what);
		errors++;
	endtask

	// Peels off decimal digits by repeated division, then queues them top digit first.
	// Only the low VALUE_BITS of the word count; the fill bit above them is dropped.
	function automatic void queue_decimal_digits(input logic [VALUE_BITS-1:0] value);
		logic [3:0]            rev [MAX_DIGITS];
		logic [VALUE_BITS-1:0] rest;
		int                    n;
		digit_t                d;
		rest = value;
		n = 0;
		do begin
			rev[n] = 4'(rest % 10);
			rest = rest / 10;
			n++;
		end while (rest != 0 && n < MAX_DIGITS);
		for (int k = 0; k < n; k++) begin
			d.digit_char = ASCII_ZERO + CHAR_W'(rev[n-1-k]);
			d.last_digit = (k == n - 1);
			expected_digits.push_back(d);
		end
	endfunction

	always @(posedge clk) begin
		digit_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				digits_seen++;
				if (expected_digits.size() == 0) begin
					report($sformatf("digit %0d arrived with nothing expected",
						m_tdata[CHAR_W-1:0]));
				end else begin
					want = expected_digits.pop_front();
					if (m_tdata[CHAR_W-1:0] !== want.digit_char)
						report($sformatf("digit_char %0d, expected %0d",
							m_tdata[CHAR_W-1:0], want.digit_char));
					if (m_tlast !== want.last_digit)
						report($sformatf("last_digit %b, expected %b",
							m_tlast, want.last_digit));
				end
			end
			if (s_tvalid && s_tready) begin
				values_seen++;
				queue_decimal_digits(s_tdata[VALUE_BITS-1:0]);
			end
			if (drained_check && expected_digits.size() != 0) begin
				report($sformatf("%0d digits never arrived", expected_digits.size()));
				expected_digits.delete();
			end
		end
		pending = expected_digits.size();
	end

endmodule

// ----- sim/tb_binary_to_decimal_ascii.sv -----
// Stimulus and verdict for the binary to decimal ASCII converter.
module tb_binary_to_decimal_ascii import b2da_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Worst case per value: ten digits each held off by a long sink stall, plus a long
	// source gap and the block's own cycles; the limit is that taken a few times over.
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_VALUES = 340;

	// Boundaries of every decimal length, the largest value, alternating bit patterns,
	// and words with the fill bit above the value set.
	localparam logic [31:0] EDGE_VALUES [25] = '{
		32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
		32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
		32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000, 32'd999999999,
		32'd1000000000, 32'd2147483647, 32'h2AAA_AAAA, 32'h5555_5555,
		32'h8000_0000, 32'hFFFF_FFFF
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;    // [30:0] value, [31] zero fill
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [5:0] digit_char, [7:6] zero fill
	logic                   m_tlast;         // last_digit
	logic                   drained_check = 1'b0;

	// Set during stretches where neither side idles.
	logic idle_free = 1'b0;
	int   sink_hold = 0;
	int   cycles = 0;

	int errors;
	int pending;
	int values_seen;
	int digits_seen;

	binary_to_decimal_ascii uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	b2da_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.drained_check (drained_check),
		.errors        (errors),
		.pending       (pending),
		.values_seen   (values_seen),
		.digits_seen   (digits_seen)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		if (r < 92)
			return $urandom_range(3, 6);
		return $urandom_range(10, 30);
	endfunction

	// Random value: usually chosen by decimal length so that every length shows up
	// often, sometimes a raw word with the fill bit random as well.
	function automatic logic [31:0] random_value();
		int     ndig;
		longint lo;
		longint hi;
		if ($urandom_range(0, 4) == 0)
			return $urandom();
		ndig = $urandom_range(1, 10);
		lo = 1;
		repeat (ndig - 1) lo = lo * 10;
		hi = lo * 10 - 1;
		if (ndig == 1)
			lo = 0;
		if (hi > 2147483647)
			hi = 2147483647;
		return 32'($urandom_range(32'(hi), 32'(lo)));
	endfunction

	// The sink stalls at random; tready changes only at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			m_tready <= 1'b1;
			if (!idle_free && $urandom_range(0, 99) < 30)
				sink_hold <= idle_length();
		end
	end

	// Presents one word and returns at the rising edge where the transfer happens.
	// tvalid is left high so that a following word can go out back to back.
	task automatic send_value(input logic [IN_TDATA_W-1:0] word);
		int gap;
		gap = (idle_free || $urandom_range(0, 99) < 50) ? 0 : idle_length();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	// Holds the source off until every digit predicted so far has been taken.
	task automatic wait_for_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (EDGE_VALUES[i])
			send_value(EDGE_VALUES[i]);
		wait_for_drain();

		// Random part in blocks; every third block runs with no idling on either side,
		// and some blocks start from an empty pipeline.
		for (int i = 0; i < RANDOM_VALUES; i++) begin
			if (i % 40 == 0) begin
				idle_free = ((i / 40) % 3 == 1);
				if ($urandom_range(0, 1) == 1)
					wait_for_drain();
			end
			send_value(random_value());
		end
		idle_free = 1'b0;

		wait_for_drain();
		repeat (30) @(posedge clk);
		@(negedge clk);
		drained_check <= 1'b1;
		@(negedge clk);

		$display("%0d values converted into %0d checked digits, every decimal length,",
			values_seen, digits_seen);
		$display("with random stalls on both streams and stall-free stretches");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
